/* src/assert_macros.svh */
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FPUD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpud check failed");

// Next-cycle implication.
`define FPUD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpud check failed");

`endif

/* src/fpud_pkg.sv */
package fpud_pkg;

  localparam int COORD_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 21;
  localparam int RAD_XBITS = 4;
  localparam int RS_W      = 21;
  localparam int R2_W      = 33;
  localparam int SQ_IN_W   = R2_W + 2 * RAD_XBITS;
  localparam int SQ_REM_W  = SQ_IN_W + 1;
  localparam int PROD_W    = COORD_W + RS_W;
  localparam int ANG_SHIFT = 3;
  localparam int ANUM_W    = PROD_W + ANG_SHIFT;
  localparam int ANG_W     = 23;
  localparam int CORD_STEPS = 23;
  localparam int CORD_W    = 28;
  localparam int Z_W       = 25;
  localparam int CV_W      = 25;
  localparam int FY_W      = COORD_W + CV_W;
  localparam int FL_W      = 21;
  localparam int FH_W      = FY_W - FL_W;
  localparam int DEN_W     = CV_W + RS_W;
  localparam int MAG_W     = COORD_W + RAD_XBITS;
  localparam int NUM_W     = 62;
  localparam int Q_W       = 21;
  localparam int CMP_W     = DEN_W + Q_W;

  localparam logic [ANG_W-1:0]  ANGLE_LIMIT = 23'd5898240;
  localparam logic [CORD_W-1:0] CORDIC_ONE  = 28'd16777216;
  localparam logic [OUT_W-1:0]  OUT_MAX     = 21'h0FFFFF;
  localparam logic [OUT_W-1:0]  OUT_MIN     = 21'h100000;

  localparam logic [COORD_W-1:0] CX_RST = 16'd12288;
  localparam logic [COORD_W-1:0] CY_RST = 16'd8192;
  localparam logic [COORD_W-1:0] FA_RST = 16'd46080;
  localparam logic [COORD_W-1:0] IR_RST = 16'd8192;
  localparam logic [COORD_W-1:0] FL_RST = 16'd7840;

  typedef enum logic [1:0] {
    KIND_CALC,
    KIND_PASS,
    KIND_ZERO,
    KIND_SAT
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE,
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_FIELD_ANGLE,
    CFG_IMAGE_RADIUS,
    CFG_FOCAL_LENGTH
  } cfg_idx_e;

  typedef struct packed {
    kind_e                   kind;
    logic signed [COORD_W:0] xn;
    logic signed [COORD_W:0] yn;
    logic [RS_W-1:0]         rs;
  } side_t;

  // atan(2^-i) in degrees, Q.16
  function automatic logic [Z_W-1:0] atan_q16(input int unsigned i);
    logic [Z_W-1:0] v;
    case (i)
      0:  v = 25'd2949120;
      1:  v = 25'd1740967;
      2:  v = 25'd919879;
      3:  v = 25'd466945;
      4:  v = 25'd234379;
      5:  v = 25'd117304;
      6:  v = 25'd58666;
      7:  v = 25'd29335;
      8:  v = 25'd14668;
      9:  v = 25'd7334;
      10: v = 25'd3667;
      11: v = 25'd1833;
      12: v = 25'd917;
      13: v = 25'd458;
      14: v = 25'd229;
      15: v = 25'd115;
      16: v = 25'd57;
      17: v = 25'd29;
      18: v = 25'd14;
      19: v = 25'd7;
      20: v = 25'd4;
      21: v = 25'd2;
      22: v = 25'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [OUT_W-1:0] sat_field(input logic signed [COORD_W:0] c);
    logic [OUT_W-1:0] v;
    if (c > 0) begin
      v = OUT_MAX;
    end else if (c < 0) begin
      v = OUT_MIN;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  // {overflow, value}
  function automatic logic [OUT_W:0] clamp_field(input logic neg, input logic big,
                                                 input logic [Q_W-1:0] q);
    logic [OUT_W:0] r;
    if (!neg) begin
      if (big || q > OUT_MAX) begin
        r = {1'b1, OUT_MAX};
      end else begin
        r = {1'b0, q};
      end
    end else begin
      if (big || q > OUT_MIN) begin
        r = {1'b1, OUT_MIN};
      end else begin
        r = {1'b0, Q_W'(0) - q};
      end
    end
    return r;
  endfunction

endpackage

/* src/fpud_if.sv */
interface fpud_in_if;
  logic                          valid;
  logic                          ready;
  logic [fpud_pkg::COORD_W-1:0]  point_x;
  logic [fpud_pkg::COORD_W-1:0]  point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface fpud_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fpud_pkg::OUT_W-1:0]  out_x;
  logic signed [fpud_pkg::OUT_W-1:0]  out_y;
  logic                               overflow;

  modport source (output valid, output out_x, output out_y, output overflow, input ready);
  modport sink   (input valid, input out_x, input out_y, input overflow, output ready);
endinterface

/* src/fpud_isqrt.sv */
module fpud_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  fpud_pkg::side_t               side_i,
  input  logic [fpud_pkg::SQ_IN_W-1:0]  v_i,
  output logic                          valid_o,
  output fpud_pkg::side_t               side_o,
  output logic [fpud_pkg::RS_W-1:0]     root_o
);
  import fpud_pkg::*;

  logic                valid_q [RS_W];
  side_t               side_q  [RS_W];
  logic [SQ_REM_W-1:0] rem_q   [RS_W];
  logic [RS_W-1:0]     root_q  [RS_W];

  // one root bit per stage, MSB first
  for (genvar s = 0; s < RS_W; s++) begin : g_st
    localparam int B = RS_W - 1 - s;
    logic                valid_in;
    side_t               side_in;
    logic [SQ_REM_W-1:0] rem_in;
    logic [RS_W-1:0]     root_in;
    logic [SQ_REM_W-1:0] trial;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign side_in  = side_i;
      assign rem_in   = SQ_REM_W'(v_i);
      assign root_in  = '0;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign side_in  = side_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign root_in  = root_q[s-1];
    end

    assign trial = (SQ_REM_W'(root_in) << (B + 1)) + (SQ_REM_W'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        if (rem_in >= trial) begin
          rem_q[s]  <= rem_in - trial;
          root_q[s] <= root_in | (RS_W'(1) << B);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  assign valid_o = valid_q[RS_W-1];
  assign side_o  = side_q[RS_W-1];
  assign root_o  = root_q[RS_W-1];

endmodule

/* src/fpud_angdiv.sv */
module fpud_angdiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  fpud_pkg::side_t               side_i,
  input  logic [fpud_pkg::ANUM_W-1:0]   num_i,
  input  logic [fpud_pkg::COORD_W-1:0]  den_i,
  output logic                          valid_o,
  output fpud_pkg::side_t               side_o,
  output logic [fpud_pkg::ANG_W-1:0]    quo_o,
  output logic                          big_o
);
  import fpud_pkg::*;

  logic              valid_q [ANG_W];
  side_t             side_q  [ANG_W];
  logic [ANUM_W-1:0] rem_q   [ANG_W];
  logic [ANG_W-1:0]  quo_q   [ANG_W];
  logic              big_q   [ANG_W];

  // restoring division, one quotient bit per stage
  for (genvar s = 0; s < ANG_W; s++) begin : g_st
    localparam int B = ANG_W - 1 - s;
    logic              valid_in;
    side_t             side_in;
    logic [ANUM_W-1:0] rem_in;
    logic [ANG_W-1:0]  quo_in;
    logic              big_in;
    logic [ANUM_W-1:0] trial;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign side_in  = side_i;
      assign rem_in   = num_i;
      assign quo_in   = '0;
      assign big_in   = num_i >= (ANUM_W'(den_i) << ANG_W);
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign side_in  = side_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign quo_in   = quo_q[s-1];
      assign big_in   = big_q[s-1];
    end

    assign trial = ANUM_W'(den_i) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        big_q[s]  <= big_in;
        if (rem_in >= trial) begin
          rem_q[s] <= rem_in - trial;
          quo_q[s] <= quo_in | (ANG_W'(1) << B);
        end else begin
          rem_q[s] <= rem_in;
          quo_q[s] <= quo_in;
        end
      end
    end
  end

  assign valid_o = valid_q[ANG_W-1];
  assign side_o  = side_q[ANG_W-1];
  assign quo_o   = quo_q[ANG_W-1];
  assign big_o   = big_q[ANG_W-1];

endmodule

/* src/fpud_cordic.sv */
module fpud_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  fpud_pkg::side_t                    side_i,
  input  logic [fpud_pkg::ANG_W-1:0]         angle_i,
  output logic                               valid_o,
  output fpud_pkg::side_t                    side_o,
  output logic signed [fpud_pkg::CORD_W-1:0] x_o,
  output logic signed [fpud_pkg::CORD_W-1:0] y_o
);
  import fpud_pkg::*;

  logic                     valid_q [CORD_STEPS];
  side_t                    side_q  [CORD_STEPS];
  logic signed [CORD_W-1:0] x_q     [CORD_STEPS];
  logic signed [CORD_W-1:0] y_q     [CORD_STEPS];
  logic signed [Z_W-1:0]    z_q     [CORD_STEPS];

  // rotation mode, one micro-rotation per stage
  for (genvar s = 0; s < CORD_STEPS; s++) begin : g_st
    logic                     valid_in;
    side_t                    side_in;
    logic signed [CORD_W-1:0] x_in;
    logic signed [CORD_W-1:0] y_in;
    logic signed [Z_W-1:0]    z_in;
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    logic signed [Z_W-1:0]    at;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign side_in  = side_i;
      assign x_in     = $signed(CORDIC_ONE);
      assign y_in     = '0;
      assign z_in     = $signed(Z_W'(angle_i));
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign side_in  = side_q[s-1];
      assign x_in     = x_q[s-1];
      assign y_in     = y_q[s-1];
      assign z_in     = z_q[s-1];
    end

    assign dx = y_in >>> s;
    assign dy = x_in >>> s;
    assign at = $signed(atan_q16(s));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        if (!z_in[Z_W-1]) begin
          x_q[s] <= x_in - dx;
          y_q[s] <= y_in + dy;
          z_q[s] <= z_in - at;
        end else begin
          x_q[s] <= x_in + dx;
          y_q[s] <= y_in - dy;
          z_q[s] <= z_in + at;
        end
      end
    end
  end

  assign valid_o = valid_q[CORD_STEPS-1];
  assign side_o  = side_q[CORD_STEPS-1];
  assign x_o     = x_q[CORD_STEPS-1];
  assign y_o     = y_q[CORD_STEPS-1];

endmodule

/* src/fpud_qdiv.sv */
module fpud_qdiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  fpud_pkg::side_t              side_i,
  input  logic [fpud_pkg::NUM_W-1:0]   numx_i,
  input  logic [fpud_pkg::NUM_W-1:0]   numy_i,
  input  logic [fpud_pkg::DEN_W-1:0]   den_i,
  output logic                         valid_o,
  output fpud_pkg::side_t              side_o,
  output logic [fpud_pkg::Q_W-1:0]     qx_o,
  output logic [fpud_pkg::Q_W-1:0]     qy_o,
  output logic                         bigx_o,
  output logic                         bigy_o
);
  import fpud_pkg::*;

  logic             valid_q [Q_W];
  side_t            side_q  [Q_W];
  logic [DEN_W-1:0] den_q   [Q_W];
  logic [NUM_W-1:0] rem_q   [Q_W][2];
  logic [Q_W-1:0]   quo_q   [Q_W][2];
  logic             big_q   [Q_W][2];

  // two lanes (x, y) sharing one divisor
  for (genvar s = 0; s < Q_W; s++) begin : g_st
    localparam int B = Q_W - 1 - s;
    logic             valid_in;
    side_t            side_in;
    logic [DEN_W-1:0] den_in;
    logic [CMP_W-1:0] trial;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign side_in  = side_i;
      assign den_in   = den_i;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign side_in  = side_q[s-1];
      assign den_in   = den_q[s-1];
    end

    assign trial = CMP_W'(den_in) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        den_q[s]  <= den_in;
      end
    end

    for (genvar c = 0; c < 2; c++) begin : g_lane
      logic [NUM_W-1:0] rem_in;
      logic [Q_W-1:0]   quo_in;
      logic             big_in;

      if (s == 0) begin : g_first
        logic [NUM_W-1:0] num;
        assign num    = (c == 0) ? numx_i : numy_i;
        assign rem_in = num;
        assign quo_in = '0;
        assign big_in = CMP_W'(num) >= (CMP_W'(den_i) << Q_W);
      end else begin : g_next
        assign rem_in = rem_q[s-1][c];
        assign quo_in = quo_q[s-1][c];
        assign big_in = big_q[s-1][c];
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          big_q[s][c] <= big_in;
          if (CMP_W'(rem_in) >= trial) begin
            rem_q[s][c] <= rem_in - NUM_W'(trial);
            quo_q[s][c] <= quo_in | (Q_W'(1) << B);
          end else begin
            rem_q[s][c] <= rem_in;
            quo_q[s][c] <= quo_in;
          end
        end
      end
    end
  end

  assign valid_o = valid_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];
  assign qx_o    = quo_q[Q_W-1][0];
  assign qy_o    = quo_q[Q_W-1][1];
  assign bigx_o  = big_q[Q_W-1][0];
  assign bigy_o  = big_q[Q_W-1][1];

endmodule

/* src/fpud_scale.sv */
module fpud_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  fpud_pkg::side_t               side_i,
  input  logic [fpud_pkg::CV_W-1:0]     x_i,
  input  logic [fpud_pkg::CV_W-1:0]     y_i,
  input  logic [fpud_pkg::COORD_W-1:0]  focal_i,
  output logic                          valid_o,
  output fpud_pkg::side_t               side_o,
  output logic [fpud_pkg::Q_W-1:0]      qx_o,
  output logic [fpud_pkg::Q_W-1:0]      qy_o,
  output logic                          bigx_o,
  output logic                          bigy_o
);
  import fpud_pkg::*;

  // stage a: focal*tan numerator and divisor
  logic             a_valid_q;
  side_t            a_side_q;
  logic [FY_W-1:0]  a_fy_q;
  logic [DEN_W-1:0] a_den_q;
  // stage b: split partial products
  logic             b_valid_q;
  side_t            b_side_q;
  logic [DEN_W-1:0] b_den_q;
  logic [MAG_W+FH_W-1:0] b_phx_q, b_phy_q;
  logic [MAG_W+FL_W-1:0] b_plx_q, b_ply_q;
  // stage c: rounded numerators
  logic             c_valid_q;
  side_t            c_side_q;
  logic [DEN_W-1:0] c_den_q;
  logic [NUM_W-1:0] c_numx_q, c_numy_q;

  logic [COORD_W-1:0] magx, magy;
  logic [MAG_W-1:0]   mx, my;

  assign magx = a_side_q.xn[COORD_W] ? COORD_W'(-a_side_q.xn) : a_side_q.xn[COORD_W-1:0];
  assign magy = a_side_q.yn[COORD_W] ? COORD_W'(-a_side_q.yn) : a_side_q.yn[COORD_W-1:0];
  assign mx   = {magx, RAD_XBITS'(0)};
  assign my   = {magy, RAD_XBITS'(0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_side_q <= side_i;
      a_fy_q   <= FY_W'(focal_i) * FY_W'(y_i);
      a_den_q  <= DEN_W'(x_i) * DEN_W'(side_i.rs);

      b_side_q <= a_side_q;
      b_den_q  <= a_den_q;
      b_phx_q  <= (MAG_W+FH_W)'(mx) * (MAG_W+FH_W)'(a_fy_q[FY_W-1:FL_W]);
      b_phy_q  <= (MAG_W+FH_W)'(my) * (MAG_W+FH_W)'(a_fy_q[FY_W-1:FL_W]);
      b_plx_q  <= (MAG_W+FL_W)'(mx) * (MAG_W+FL_W)'(a_fy_q[FL_W-1:0]);
      b_ply_q  <= (MAG_W+FL_W)'(my) * (MAG_W+FL_W)'(a_fy_q[FL_W-1:0]);

      c_side_q <= b_side_q;
      c_den_q  <= b_den_q;
      c_numx_q <= (NUM_W'(b_phx_q) << FL_W) + NUM_W'(b_plx_q) + NUM_W'(b_den_q >> 1);
      c_numy_q <= (NUM_W'(b_phy_q) << FL_W) + NUM_W'(b_ply_q) + NUM_W'(b_den_q >> 1);
    end
  end

  fpud_qdiv u_qdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (c_valid_q),
    .side_i  (c_side_q),
    .numx_i  (c_numx_q),
    .numy_i  (c_numy_q),
    .den_i   (c_den_q),
    .valid_o (valid_o),
    .side_o  (side_o),
    .qx_o    (qx_o),
    .qy_o    (qy_o),
    .bigx_o  (bigx_o),
    .bigy_o  (bigy_o)
  );

endmodule

/* src/fisheye_point_undistort.sv */
// Equidistant fisheye to pinhole remapping of one keypoint per clock. A point
// (Q12.4) is centered on the configured center, its radius goes through a
// 21-stage square root, the field angle through a 23-stage divider, tan() through
// a 23-stage CORDIC, and the x/y scale through a 21-stage dual divider; the
// result is signed Q16.4 relative to the center, saturated, with an overflow
// flag. A new point is taken every cycle while the pipeline is not held. The
// whole pipeline holds while the output register is full and not taken, so
// in_i.ready is low only then. Configuration registers feed the pipeline
// directly: write them only while no point is in flight. With fisheye_enable
// low the point passes through as is.
module fisheye_point_undistort (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fpud_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fpud_pkg::COORD_W-1:0]    cfg_wdata_i,
  fpud_in_if.sink                         in_i,
  fpud_out_if.source                      out_o
);
  import fpud_pkg::*;

  logic               fe_q;
  logic [COORD_W-1:0] cx_q, cy_q, fa_q, ir_q, fl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_q <= 1'b0;
      cx_q <= CX_RST;
      cy_q <= CY_RST;
      fa_q <= FA_RST;
      ir_q <= IR_RST;
      fl_q <= FL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:       fe_q <= cfg_wdata_i[0];
        CFG_CENTER_X:     cx_q <= cfg_wdata_i;
        CFG_CENTER_Y:     cy_q <= cfg_wdata_i;
        CFG_FIELD_ANGLE:  fa_q <= cfg_wdata_i;
        CFG_IMAGE_RADIUS: ir_q <= cfg_wdata_i;
        CFG_FOCAL_LENGTH: fl_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  logic signed [OUT_W-1:0] out_x_q, out_y_q;
  logic out_ovf_q;

  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;

  // s0: center
  side_t s0_side_d, s0_side_q;
  logic  s0_valid_q;

  always_comb begin
    s0_side_d    = '0;
    if (!fe_q) begin
      s0_side_d.kind = KIND_PASS;
      s0_side_d.xn   = $signed({1'b0, in_i.point_x});
      s0_side_d.yn   = $signed({1'b0, in_i.point_y});
    end else begin
      s0_side_d.kind = (in_i.point_x == cx_q && in_i.point_y == cy_q) ? KIND_ZERO : KIND_CALC;
      s0_side_d.xn   = $signed({1'b0, in_i.point_x}) - $signed({1'b0, cx_q});
      s0_side_d.yn   = $signed({1'b0, in_i.point_y}) - $signed({1'b0, cy_q});
    end
  end

  // s1: squared radius
  logic                       s1_valid_q;
  side_t                      s1_side_q;
  logic [R2_W-1:0]            s1_r2_q;
  logic signed [2*COORD_W+1:0] sqx, sqy;

  assign sqx = s0_side_q.xn * s0_side_q.xn;
  assign sqy = s0_side_q.yn * s0_side_q.yn;

  // sp: field_angle * r
  logic              sq_valid, sp_valid_q;
  side_t             sq_side, sp_side_q;
  logic [RS_W-1:0]   sq_root;
  logic [PROD_W-1:0] sp_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      sp_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_i.valid;
      s1_valid_q <= s0_valid_q;
      sp_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_side_q <= s0_side_d;
      s1_side_q <= s0_side_q;
      s1_r2_q   <= R2_W'(sqx) + R2_W'(sqy);
      sp_side_q <= '{kind: sq_side.kind, xn: sq_side.xn, yn: sq_side.yn, rs: sq_root};
      sp_prod_q <= PROD_W'(fa_q) * PROD_W'(sq_root);
    end
  end

  fpud_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid_q),
    .side_i  (s1_side_q),
    .v_i     ({s1_r2_q, (2*RAD_XBITS)'(0)}),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .root_o  (sq_root)
  );

  logic             ad_valid, ad_big;
  side_t            ad_side, cd_in_side;
  logic [ANG_W-1:0] ad_quo;

  fpud_angdiv u_angdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sp_valid_q),
    .side_i  (sp_side_q),
    .num_i   ({sp_prod_q, ANG_SHIFT'(0)}),
    .den_i   (ir_q),
    .valid_o (ad_valid),
    .side_o  (ad_side),
    .quo_o   (ad_quo),
    .big_o   (ad_big)
  );

  // angle at or past 90 degrees (or zero radius) saturates
  always_comb begin
    cd_in_side = ad_side;
    if (ad_side.kind == KIND_CALC && (ad_big || ad_quo >= ANGLE_LIMIT)) begin
      cd_in_side.kind = KIND_SAT;
    end
  end

  logic                     cd_valid;
  side_t                    cd_side, sc_in_side;
  logic signed [CORD_W-1:0] cd_x, cd_y;
  logic [CV_W-1:0]          sc_in_x, sc_in_y;

  fpud_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ad_valid),
    .side_i  (cd_in_side),
    .angle_i (ad_quo),
    .valid_o (cd_valid),
    .side_o  (cd_side),
    .x_o     (cd_x),
    .y_o     (cd_y)
  );

  always_comb begin
    sc_in_side = cd_side;
    if (cd_side.kind == KIND_CALC && (cd_x[CORD_W-1] || cd_x == '0)) begin
      sc_in_side.kind = KIND_SAT;
    end
    sc_in_x = cd_x[CV_W-1:0];
    sc_in_y = cd_y[CORD_W-1] ? '0 : cd_y[CV_W-1:0];
  end

  logic           sc_valid, sc_bigx, sc_bigy;
  side_t          sc_side;
  logic [Q_W-1:0] sc_qx, sc_qy;

  fpud_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cd_valid),
    .side_i  (sc_in_side),
    .x_i     (sc_in_x),
    .y_i     (sc_in_y),
    .focal_i (fl_q),
    .valid_o (sc_valid),
    .side_o  (sc_side),
    .qx_o    (sc_qx),
    .qy_o    (sc_qy),
    .bigx_o  (sc_bigx),
    .bigy_o  (sc_bigy)
  );

  logic [OUT_W-1:0] fin_x, fin_y;
  logic             fin_ovf;
  logic [OUT_W:0]   clx, cly;

  always_comb begin
    clx     = clamp_field(sc_side.xn[COORD_W], sc_bigx, sc_qx);
    cly     = clamp_field(sc_side.yn[COORD_W], sc_bigy, sc_qy);
    fin_x   = '0;
    fin_y   = '0;
    fin_ovf = 1'b0;
    case (sc_side.kind)
      KIND_PASS: begin
        fin_x = OUT_W'(sc_side.xn[COORD_W-1:0]);
        fin_y = OUT_W'(sc_side.yn[COORD_W-1:0]);
      end
      KIND_ZERO: ;
      KIND_SAT: begin
        fin_x   = sat_field(sc_side.xn);
        fin_y   = sat_field(sc_side.yn);
        fin_ovf = 1'b1;
      end
      KIND_CALC: begin
        fin_x   = clx[OUT_W-1:0];
        fin_y   = cly[OUT_W-1:0];
        fin_ovf = clx[OUT_W] | cly[OUT_W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sc_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q   <= $signed(fin_x);
      out_y_q   <= $signed(fin_y);
      out_ovf_q <= fin_ovf;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_x    = out_x_q;
  assign out_o.out_y    = out_y_q;
  assign out_o.overflow = out_ovf_q;

endmodule

/* src/fpud_checker.sv */
`include "assert_macros.svh"

module fpud_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic signed [fpud_pkg::OUT_W-1:0] out_x_i,
  input logic signed [fpud_pkg::OUT_W-1:0] out_y_i,
  input logic                            overflow_i
);
  import fpud_pkg::*;

  logic x_bound, y_bound;

  assign x_bound = out_x_i == $signed(OUT_MAX) || out_x_i == $signed(OUT_MIN);
  assign y_bound = out_y_i == $signed(OUT_MAX) || out_y_i == $signed(OUT_MIN);

  // input side stalls only behind a full, untaken output register
  `FPUD_ASSERT_IMP(a_ready_link, clk_i, rst_ni, in_valid_i || !in_valid_i, in_ready_i == (!out_valid_i || out_ready_i))
  // an overflowing result sits on a bound in at least one coordinate
  `FPUD_ASSERT_IMP(a_ovf_bound, clk_i, rst_ni, out_valid_i && overflow_i, x_bound || y_bound)
  `FPUD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `FPUD_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_x_i) && $stable(out_y_i) && $stable(overflow_i))

endmodule

bind fisheye_point_undistort fpud_checker u_fpud_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_x_i     (out_o.out_x),
  .out_y_i     (out_o.out_y),
  .overflow_i  (out_o.overflow)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import fpud_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int LATENCY = 95;
  localparam int SETTLE = LATENCY + 10;
  localparam int LONG_HOLD = 400;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam longint ANGLE_90 = 90 * 65536;
  localparam longint ATAN_Q16 [23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  typedef struct {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } point_t;

  typedef struct {
    logic [OUT_W-1:0] ox;
    logic [OUT_W-1:0] oy;
    logic             ovf;
  } remap_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COORD_W-1:0] cfg_wdata_i;

  fpud_in_if in_if ();
  fpud_out_if out_if ();

  fisheye_point_undistort dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // shadow of the configuration
  logic        m_enable;
  longint      m_cx, m_cy, m_fa, m_ir, m_fl;

  point_t pending_pts [$];
  remap_t expected_pts [$];
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_req = 1'b0;
  logic sink_blocked = 1'b0;
  int n_errors = 0;
  int n_checked = 0;
  int n_sat = 0;
  int n_pass = 0;
  longint cycles = 0;

  function automatic longint root_floor(longint v);
    longint res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [OUT_W-1:0] rail(longint c);
    if (c > 0) return OUT_MAX;
    if (c < 0) return OUT_MIN;
    return '0;
  endfunction

  function automatic logic [OUT_W:0] scale_coord(longint c, longint mulv, longint den);
    longint mag, q;
    mag = (c < 0) ? -c : c;
    q = ((mag << 4) * mulv + den / 2) / den;
    if (c >= 0) begin
      if (q > 1048575) return {1'b1, OUT_MAX};
      return {1'b0, q[OUT_W-1:0]};
    end
    if (q > 1048576) return {1'b1, OUT_MIN};
    return {1'b0, OUT_W'(-q)};
  endfunction

  function automatic remap_t undistort(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    longint xn, yn, r2, rs, ang, x, y, z, dx, dy, den, mulv;
    logic [OUT_W:0] sx, sy;
    remap_t r;
    if (!m_enable) begin
      r.ox = {5'b0, px};
      r.oy = {5'b0, py};
      r.ovf = 1'b0;
      return r;
    end
    xn = longint'(px) - m_cx;
    yn = longint'(py) - m_cy;
    r2 = xn * xn + yn * yn;
    r = '{ox: '0, oy: '0, ovf: 1'b0};
    if (r2 == 0) return r;
    rs = root_floor(r2 << 8);
    r = '{ox: rail(xn), oy: rail(yn), ovf: 1'b1};
    if (m_ir == 0) return r;
    ang = ((m_fa * rs) << 16) >> 13;
    ang = ang / m_ir;
    if (ang >= ANGLE_90) return r;
    x = 64'd16777216;
    y = 0;
    z = ang;
    for (int i = 0; i < 23; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_Q16[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_Q16[i];
      end
    end
    if (y < 0) y = 0;
    if (x <= 0) return r;
    den = x * rs;
    mulv = m_fl * y;
    sx = scale_coord(xn, mulv, den);
    sy = scale_coord(yn, mulv, den);
    r.ox = sx[OUT_W-1:0];
    r.oy = sy[OUT_W-1:0];
    r.ovf = sx[OUT_W] | sy[OUT_W];
    return r;
  endfunction

  task automatic report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    $display("mismatch %s: got %0h want %0h (transfer %0d)", what, got, want, n_checked);
    n_errors++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.point_x <= '0;
      in_if.point_y <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_pts.insert(expected_pts.size(), undistort(in_if.point_x, in_if.point_y));
        void'(pending_pts.pop_front());
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (pending_pts.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.point_x <= pending_pts[0].px;
          in_if.point_y <= pending_pts[0].py;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    remap_t w;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_pts.size() == 0) begin
          $display("unexpected result transfer %0h %0h", out_if.out_x, out_if.out_y);
          n_errors++;
        end else begin
          w = expected_pts.pop_front();
          if (out_if.out_x !== w.ox) report("out_x", out_if.out_x, w.ox);
          if (out_if.out_y !== w.oy) report("out_y", out_if.out_y, w.oy);
          if (out_if.overflow !== w.ovf) report("overflow", {20'b0, out_if.overflow}, {20'b0, w.ovf});
          if (w.ovf) n_sat++;
          n_checked++;
        end
      end
      out_if.ready <= !sink_blocked && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // long receiver hold-off
  always begin
    wait (hold_req);
    @(posedge clk_i);
    sink_blocked <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    sink_blocked <= 1'b0;
    hold_req = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("fisheye_point_undistort regression: fail");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENABLE:       m_enable = val[0];
      CFG_CENTER_X:     m_cx = val;
      CFG_CENTER_Y:     m_cy = val;
      CFG_FIELD_ANGLE:  m_fa = val;
      CFG_IMAGE_RADIUS: m_ir = val;
      CFG_FOCAL_LENGTH: m_fl = val;
      default: ;
    endcase
  endtask

  task automatic set_lens(logic [15:0] cx, logic [15:0] cy, logic [15:0] fa,
                          logic [15:0] ir, logic [15:0] fl);
    cfg_write(CFG_CENTER_X, cx);
    cfg_write(CFG_CENTER_Y, cy);
    cfg_write(CFG_FIELD_ANGLE, fa);
    cfg_write(CFG_IMAGE_RADIUS, ir);
    cfg_write(CFG_FOCAL_LENGTH, fl);
  endtask

  task automatic push_pt(int x, int y);
    pending_pts.insert(pending_pts.size(), '{px: x[15:0], py: y[15:0]});
  endtask

  task automatic push_random(int n);
    int dx, dy;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 6) begin
        dx = int'($urandom_range(0, 2 * m_ir + 16)) - int'(m_ir) - 8;
        dy = int'($urandom_range(0, 2 * m_ir + 16)) - int'(m_ir) - 8;
        dx = int'(m_cx) + dx / int'($urandom_range(1, 3));
        dy = int'(m_cy) + dy / int'($urandom_range(1, 3));
        push_pt(dx < 0 ? 0 : (dx > 65535 ? 65535 : dx),
                dy < 0 ? 0 : (dy > 65535 ? 65535 : dy));
      end else begin
        push_pt(int'($urandom_range(65535)), int'($urandom_range(65535)));
      end
    end
  endtask

  task automatic drain();
    while (pending_pts.size() != 0 || expected_pts.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    m_enable = 1'b0;
    m_cx = CX_RST;
    m_cy = CY_RST;
    m_fa = FA_RST;
    m_ir = IR_RST;
    m_fl = FL_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass through at reset settings
    push_pt(0, 0);
    push_pt(65535, 65535);
    push_pt(16'h5555, 16'hAAAA);
    push_pt(12288, 8192);
    drain();

    // undistortion with reset lens
    cfg_write(CFG_ENABLE, 16'd1);
    push_pt(12288, 8192);
    push_pt(0, 0);
    push_pt(65535, 65535);
    push_pt(0, 65535);
    push_pt(65535, 0);
    push_pt(12288 + 100, 8192);
    push_pt(12288, 8192 - 100);
    push_pt(12288 + 4000, 8192 + 3000);
    push_pt(12288 - 7000, 8192 + 3500);
    push_pt(12288 + 1, 8192 - 1);
    drain();

    // lens extremes: tiny radius, zero radius, zero angle, huge focal
    set_lens(16'd0, 16'd65535, 16'd65535, 16'd1, 16'd65535);
    push_pt(0, 65535);
    push_pt(1, 65535);
    push_pt(65535, 0);
    drain();
    cfg_write(CFG_IMAGE_RADIUS, 16'd0);
    push_pt(100, 200);
    push_pt(0, 65535);
    drain();
    set_lens(16'd32768, 16'd32768, 16'd0, 16'd65535, 16'd1);
    push_pt(0, 0);
    push_pt(65535, 65535);
    drain();
    set_lens(16'd32768, 16'd32768, 16'd46080, 16'd65535, 16'd65535);
    push_pt(0, 0);
    push_pt(65535, 32768);
    push_pt(32768, 65535);
    drain();
    // spare index is ignored, enable takes bit 0 only
    cfg_write(CFG_SPARE, 16'hFFFF);
    cfg_write(CFG_ENABLE, 16'hFFFE);
    push_pt(1234, 4321);
    drain();
    cfg_write(CFG_ENABLE, 16'h0001);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
        1: begin src_idle_pct = 58; snk_idle_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_idle_pct = 58; end
        default: begin src_idle_pct = 22; snk_idle_pct = 22; end
      endcase
      if (ph == 11) begin
        cfg_write(CFG_ENABLE, 16'd0);
      end else if (ph > 0) begin
        set_lens(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                 (ph % 3 == 0) ? 16'hFFFF : 16'($urandom_range(65535)),
                 (ph == 5) ? 16'd1 : 16'($urandom_range(64, 20000)),
                 (ph == 7) ? 16'hFFFF : 16'($urandom_range(1, 65535)));
      end
      if (ph == 4) begin
        push_random(300);
        hold_req = 1'b1;
        push_random(40);
      end else begin
        push_random(35);
        if (ph == 1) drain();
        push_random(35);
      end
      drain();
    end

    $display("checked %0d transfers over 12 lens settings and 4 flow patterns", n_checked);
    $display("%0d results saturated or overflowed, %0d mismatches", n_sat, n_errors);
    if (n_errors == 0) begin
      $display("fisheye_point_undistort regression: pass");
    end else begin
      $display("fisheye_point_undistort regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/fpud_pkg.sv
src/fpud_if.sv
src/fpud_isqrt.sv
src/fpud_angdiv.sv
src/fpud_cordic.sv
src/fpud_qdiv.sv
src/fpud_scale.sv
src/fisheye_point_undistort.sv
src/fpud_checker.sv
sim/tb_top.sv
